// ===== rtl/core/uma_pkg.sv =====
package uma_pkg;

   localparam int unsigned CNT_W  = 4;
   localparam int unsigned MAP_W  = 64;
   localparam int unsigned CH_W   = 3;
   localparam int unsigned USER_W = 3;
   localparam int unsigned MODE_W = 2;

   // Channel modes as they arrive in a transaction
   localparam logic [MODE_W-1:0] MODE_NO     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SILENT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FULL   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   channel;
      logic [MODE_W-1:0] previous_mode;
      logic [MODE_W-1:0] current_mode;
      logic [USER_W-1:0] user;
   } uma_req_type;

   typedef struct packed {
      logic [MODE_W-1:0] least_mode;
      logic [CNT_W-1:0]  no_com_channels;
      logic [CNT_W-1:0]  silent_channels;
      logic [CNT_W-1:0]  full_channels;
   } uma_rsp_type;

   // One user's three counters
   typedef struct packed {
      logic [CNT_W-1:0] no_com;
      logic [CNT_W-1:0] silent;
      logic [CNT_W-1:0] full;
   } uma_cnt_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } uma_state_type;

endpackage

// ===== rtl/core/uma_sat_unit.sv =====
module uma_sat_unit #(
   parameter int unsigned LIMIT = 8
) (
   input  uma_pkg::uma_cnt_type         cnt_i,
   input  logic [uma_pkg::MODE_W-1:0]   prev_mode,
   input  logic [uma_pkg::MODE_W-1:0]   cur_mode,
   output uma_pkg::uma_cnt_type         cnt_o
);
   import uma_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LIMIT);

   function automatic logic [CNT_W-1:0] adjust(
      input logic [CNT_W-1:0]  value,
      input logic [MODE_W-1:0] own,
      input logic [MODE_W-1:0] from_mode,
      input logic [MODE_W-1:0] to_mode
   );
      logic [CNT_W-1:0] v;
      v = value;
      // decrement saturates at zero, increment at the channel count
      if (from_mode == own && v != '0) begin
         v = v - 1'b1;
      end
      if (to_mode == own && v < CNT_LIMIT) begin
         v = v + 1'b1;
      end
      return v;
   endfunction

   always_comb begin
      cnt_o.no_com = adjust(cnt_i.no_com, MODE_NO, prev_mode, cur_mode);
      cnt_o.silent = adjust(cnt_i.silent, MODE_SILENT, prev_mode, cur_mode);
      cnt_o.full   = adjust(cnt_i.full, MODE_FULL, prev_mode, cur_mode);
   end

endmodule

// ===== rtl/core/user_mode_aggregator_core.sv =====
// Per-user communication mode aggregator. csr_data holds the channel-to-user
// membership map (bit channel*8+user). A report transaction (kind 0) with
// differing old and new modes on a channel below NUM_CHANNELS is accepted and
// then walks the users, one per cycle, through a single shared saturating
// counter adjust unit: the block stays busy until the last user is done and
// takes nothing on req_ meanwhile. A report that changes nothing starts no walk.
// A query (kind 1) reads one user's counters and registers the response in the
// cycle it is accepted; rsp_valid rises the next cycle, and a new transaction
// is taken while the response is being consumed.
// Counters clear at reset and saturate at 0 and NUM_CHANNELS.
module user_mode_aggregator_core #(
   parameter int unsigned NUM_USERS    = 8,
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  uma_pkg::uma_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output uma_pkg::uma_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [uma_pkg::MAP_W-1:0]   csr_data
);
   import uma_pkg::*;

   localparam int unsigned USER_IDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam logic [USER_IDX_W-1:0] LAST_USER = USER_IDX_W'(NUM_USERS - 1);

   uma_state_type         state_ff, state_in;
   logic [MAP_W-1:0]      map_ff;
   uma_cnt_type           cnt_ff [NUM_USERS];
   logic [USER_IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CH_W-1:0]       ch_ff;
   logic [MODE_W-1:0]     prev_ff, cur_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   uma_rsp_type           rsp_ff, rsp_in;

   logic                  req_fire, rsp_free, walk_member;
   logic                  report_live, user_ok;
   uma_cnt_type           walk_cnt, walk_next, query_cnt;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign report_live = ({1'b0, req_data.channel} < (CH_W + 1)'(NUM_CHANNELS)) &&
                        (req_data.previous_mode != req_data.current_mode);
   assign user_ok     = {1'b0, req_data.user} < (USER_W + 1)'(NUM_USERS);

   assign walk_cnt    = cnt_ff[walk_idx_ff];
   assign walk_member = map_ff[{ch_ff, USER_W'(walk_idx_ff)}];

   uma_sat_unit #(
      .LIMIT(NUM_CHANNELS)
   ) u_sat (
      .cnt_i    (walk_cnt),
      .prev_mode(prev_ff),
      .cur_mode (cur_ff),
      .cnt_o    (walk_next)
   );

   always_comb begin
      query_cnt = '0;
      if (user_ok) begin
         query_cnt = cnt_ff[req_data.user[USER_IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      walk_idx_in  = walk_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_QUERY) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.no_com_channels = query_cnt.no_com;
                  rsp_in.silent_channels = query_cnt.silent;
                  rsp_in.full_channels   = query_cnt.full;
                  if (query_cnt.no_com != '0) begin
                     rsp_in.least_mode = MODE_NO;
                  end else if (query_cnt.silent != '0) begin
                     rsp_in.least_mode = MODE_SILENT;
                  end else begin
                     rsp_in.least_mode = MODE_FULL;
                  end
               end else if (report_live) begin
                  state_in    = ST_WALK;
                  walk_idx_in = '0;
               end
            end
         end
         ST_WALK: begin
            walk_idx_in = walk_idx_ff + 1'b1;
            if (walk_idx_ff == LAST_USER) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
         walk_idx_ff  <= '0;
         for (int i = 0; i < NUM_USERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_idx_ff  <= walk_idx_in;
         if (csr_valid && csr_ready) begin
            map_ff <= csr_data;
         end
         if (state_ff == ST_WALK && walk_member) begin
            cnt_ff[walk_idx_ff] <= walk_next;
         end
      end
   end

   // Hold the report fields for the walk, and register the response
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_fire) begin
         ch_ff   <= req_data.channel;
         prev_ff <= req_data.previous_mode;
         cur_ff  <= req_data.current_mode;
      end
   end

endmodule

// ===== rtl/core/uma_checker.sv =====
module uma_checker #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input uma_pkg::uma_req_type  req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input uma_pkg::uma_rsp_type  rsp_data
);
   import uma_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(NUM_CHANNELS);

   a_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.kind == KIND_QUERY) |=> rsp_valid)
      else $error("query transaction produced no response");

   a_least_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.no_com_channels != '0 && rsp_data.least_mode == MODE_NO) ||
          (rsp_data.no_com_channels == '0 && rsp_data.silent_channels != '0 &&
           rsp_data.least_mode == MODE_SILENT) ||
          (rsp_data.no_com_channels == '0 && rsp_data.silent_channels == '0 &&
           rsp_data.least_mode == MODE_FULL)))
      else $error("least mode disagrees with counts");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.no_com_channels <= CNT_LIMIT &&
                     rsp_data.silent_channels <= CNT_LIMIT &&
                     rsp_data.full_channels <= CNT_LIMIT))
      else $error("count above channel limit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

endmodule

bind user_mode_aggregator_core uma_checker #(
   .NUM_CHANNELS(NUM_CHANNELS)
) u_uma_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ===== tb/user_mode_aggregator_core_tb.sv =====
module user_mode_aggregator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uma_pkg::*;

   localparam int unsigned NUM_USERS    = 8;
   localparam int unsigned NUM_CHANNELS = 8;
   localparam int unsigned WALK_CYCLES  = NUM_USERS + 4;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASE_ITEMS  = 105;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   uma_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   uma_rsp_type       rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [MAP_W-1:0]  csr_data;

   // predicted block state
   logic [MAP_W-1:0]  member_map;
   uma_cnt_type       user_counts [NUM_USERS];
   logic [MODE_W-1:0] tracked_mode [NUM_CHANNELS];
   uma_rsp_type       expected_status [$];

   logic              idle_on;
   int unsigned       error_count;
   int unsigned       cycle_count;

   user_mode_aggregator_core #(
      .NUM_USERS    (NUM_USERS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] count, bit up);
      if (up) begin
         return (count < NUM_CHANNELS) ? count + 1'b1 : count;
      end
      return (count > 0) ? count - 1'b1 : count;
   endfunction

   function automatic void adjust_count(int unsigned u, logic [MODE_W-1:0] mode, bit up);
      case (mode)
         MODE_NO: begin
            user_counts[u].no_com = bump(user_counts[u].no_com, up);
         end
         MODE_SILENT: begin
            user_counts[u].silent = bump(user_counts[u].silent, up);
         end
         MODE_FULL: begin
            user_counts[u].full = bump(user_counts[u].full, up);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void apply_mode_change(uma_req_type item);
      if (item.channel >= NUM_CHANNELS || item.previous_mode == item.current_mode) begin
         return;
      end
      for (int unsigned u = 0; u < NUM_USERS; u++) begin
         if (member_map[item.channel * 8 + u]) begin
            adjust_count(u, item.previous_mode, 1'b0);
            adjust_count(u, item.current_mode, 1'b1);
         end
      end
   endfunction

   function automatic uma_rsp_type user_status(logic [USER_W-1:0] user);
      uma_rsp_type status;
      status = '0;
      if (user < NUM_USERS) begin
         status.no_com_channels = user_counts[user].no_com;
         status.silent_channels = user_counts[user].silent;
         status.full_channels   = user_counts[user].full;
      end
      if (status.no_com_channels != 0) begin
         status.least_mode = MODE_NO;
      end else if (status.silent_channels != 0) begin
         status.least_mode = MODE_SILENT;
      end else begin
         status.least_mode = MODE_FULL;
      end
      return status;
   endfunction

   function automatic uma_req_type report_item(int unsigned channel,
                                               logic [MODE_W-1:0] old_mode,
                                               logic [MODE_W-1:0] new_mode);
      uma_req_type item;
      item               = uma_req_type'($urandom);
      item.kind          = KIND_REPORT;
      item.channel       = CH_W'(channel);
      item.previous_mode = old_mode;
      item.current_mode  = new_mode;
      return item;
   endfunction

   function automatic uma_req_type query_item(int unsigned user);
      uma_req_type item;
      item      = uma_req_type'($urandom);
      item.kind = KIND_QUERY;
      item.user = USER_W'(user);
      return item;
   endfunction

   // Queries, mostly consistent mode transitions per channel, some raw noise
   function automatic uma_req_type random_item();
      uma_req_type       item;
      logic [MODE_W-1:0] next_mode;
      int unsigned       pick;
      item = uma_req_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         item.kind = KIND_QUERY;
      end else if (pick < 85) begin
         item.kind          = KIND_REPORT;
         item.previous_mode = tracked_mode[item.channel];
         next_mode          = MODE_W'($urandom_range(0, 3));
         while (next_mode == item.previous_mode) begin
            next_mode = MODE_W'($urandom_range(0, 3));
         end
         item.current_mode            = next_mode;
         tracked_mode[item.channel]   = next_mode;
      end else begin
         item.kind = KIND_REPORT;
      end
      return item;
   endfunction

   task automatic send_item(uma_req_type item);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.kind == KIND_QUERY) begin
         expected_status.push_back(user_status(item.user));
      end else begin
         apply_mode_change(item);
      end
   endtask

   // Drop valid, drain responses, then cover a trailing user walk
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (WALK_CYCLES) @(negedge clock);
   endtask

   task automatic write_member_map(logic [MAP_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      member_map = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      idle_on = 1'b1;
      send_item(report_item(0, MODE_NONE, MODE_FULL));
      send_item(query_item(0));
      send_item(query_item(7));
      settle();
   endtask

   task automatic test_directed_cases();
      idle_on = 1'b1;
      write_member_map('1);
      for (int unsigned ch = 0; ch < NUM_CHANNELS; ch++) begin
         send_item(report_item(ch, MODE_NONE, MODE_FULL));
      end
      // one more increment past the limit
      send_item(report_item(0, MODE_NONE, MODE_FULL));
      send_item(query_item(0));
      send_item(query_item(7));
      send_item(report_item(7, MODE_FULL, MODE_FULL));
      send_item(report_item(3, MODE_FULL, MODE_SILENT));
      send_item(report_item(5, MODE_SILENT, MODE_NO));
      send_item(query_item(3));
      // second one decrements a zero counter
      send_item(report_item(2, MODE_NO, MODE_NONE));
      send_item(report_item(2, MODE_NO, MODE_NONE));
      send_item(query_item(4));
      write_member_map(64'h8000_0000_0000_0001);
      send_item(report_item(0, MODE_FULL, MODE_NO));
      send_item(report_item(7, MODE_NONE, MODE_SILENT));
      send_item(query_item(0));
      send_item(query_item(7));
      send_item(query_item(3));
      settle();
   endtask

   task automatic test_random_traffic(logic [MAP_W-1:0] map_value, bit with_idle);
      write_member_map(map_value);
      idle_on = with_idle;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
         send_item(random_item());
      end
      settle();
      idle_on = 1'b1;
   endtask

   // response checker
   always @(posedge clock) begin : check_response
      uma_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            $error("response with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.least_mode !== want.least_mode) begin
               $error("least_mode expected %0d actual %0d",
                      want.least_mode, rsp_data.least_mode);
               error_count++;
            end
            if (rsp_data.no_com_channels !== want.no_com_channels) begin
               $error("no_com_channels expected %0d actual %0d",
                      want.no_com_channels, rsp_data.no_com_channels);
               error_count++;
            end
            if (rsp_data.silent_channels !== want.silent_channels) begin
               $error("silent_channels expected %0d actual %0d",
                      want.silent_channels, rsp_data.silent_channels);
               error_count++;
            end
            if (rsp_data.full_channels !== want.full_channels) begin
               $error("full_channels expected %0d actual %0d",
                      want.full_channels, rsp_data.full_channels);
               error_count++;
            end
         end
      end
   end

   // response side: random stall before taking each response while idle_on is set
   initial begin : drive_rsp_ready
      int unsigned stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      idle_on     = 1'b1;
      error_count = 0;
      member_map  = '0;
      for (int unsigned u = 0; u < NUM_USERS; u++) begin
         user_counts[u] = '0;
      end
      for (int unsigned ch = 0; ch < NUM_CHANNELS; ch++) begin
         tracked_mode[ch] = MODE_NONE;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_random_traffic('1, 1'b1);
      test_random_traffic({$urandom, $urandom}, 1'b1);
      test_random_traffic('0, 1'b1);
      test_random_traffic(64'hAAAA_5555_AAAA_5555, 1'b1);
      test_random_traffic('1, 1'b0);
      test_random_traffic({$urandom, $urandom}, 1'b1);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/uma_pkg.sv
rtl/core/uma_sat_unit.sv
rtl/core/user_mode_aggregator_core.sv
rtl/core/uma_checker.sv
tb/user_mode_aggregator_core_tb.sv
